@@ design/lvu_pkg.sv @@
// lvu_pkg: field widths, register indexes and pipeline depths for the
// langevin velocity update block; no dependencies
`timescale 1ns / 1ps

package lvu_pkg;

    // field widths
    localparam int VEL_W   = 32;
    localparam int MASS_W  = 24;
    localparam int NOISE_W = 16;
    localparam int C1_W    = 17;
    localparam int C2_W    = 32;

    // configuration register indexes
    localparam logic CFG_DECAY = 1'b0;
    localparam logic CFG_NOISE = 1'b1;

    // unity decay factor in Q1.16
    localparam logic [C1_W-1:0] C1_ONE = 17'd65536;

    // divider: 50-bit dividend, one quotient bit per stage
    localparam int DIV_W = 50;
    // square root: two radicand bits per stage
    localparam int SQ_N  = DIV_W / 2;
    localparam int ROOT_W = SQ_N;
    localparam int SREM_W = ROOT_W + 2;

    // product widths
    localparam int PROD_W = C2_W + ROOT_W;   // c2 * root
    localparam int A_W    = PROD_W - 20;     // rounded noise amplitude
    localparam int CV_W   = C1_W + 1 + VEL_W; // signed c1 * v
    localparam int AN_W   = A_W + 1 + NOISE_W; // signed a * noise
    localparam int SUM_W  = 58;

    typedef logic [VEL_W-1:0]   t_vel;
    typedef logic [MASS_W-1:0]  t_mass;
    typedef logic [NOISE_W-1:0] t_noise;

endpackage

@@ design/langevin_velocity_update.sv @@
// langevin_velocity_update: top level, c1*v + c2*sqrt((c1+1)/mass)*noise
// with rounding and saturation; depends on lvu_pkg
`timescale 1ns / 1ps
//
// channel   dir  signals                      contents
// s axis    in   i_s_tvalid/o_s_tready/tdata  velocity, mass, noise
// m axis    out  o_m_tvalid/i_m_tready/tdata  new_velocity; tuser saturated
// config    in   i_cfg_we/i_cfg_addr/wdata    decay_factor, noise_scale
//
// one transaction per clock while the output is not stalled; 81 register stages:
// input register, 50 divider stages, a hand-off stage, 25 square root stages,
// three multiply stages and the output register.
// the bit-serial divider and root chains set the depth.
// reset clears valid bits and loads decay 1.0, noise scale 0.
// a stalled output freezes the whole pipeline; nothing is lost or repeated.

module langevin_velocity_update
    import lvu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,   // velocity[31:0], mass[55:32], noise[71:56]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // new_velocity[31:0]
    output logic        o_m_tuser,   // saturated[0]
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    // configuration registers
    logic [C1_W-1:0] r_decay;
    logic [C2_W-1:0] r_nscale;
    logic [C1_W-1:0] c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= C1_ONE;
            r_nscale <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_DECAY: r_decay  <= i_cfg_wdata[C1_W-1:0];
                CFG_NOISE: r_nscale <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign c1 = (r_decay > C1_ONE) ? C1_ONE : r_decay;

    // global advance: whole pipeline moves unless the output is held
    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || i_m_tready;
    assign o_s_tready = en;

    // divider stages
    logic              r_dv_valid [0:DIV_W];
    logic [MASS_W-1:0] r_dv_rem   [0:DIV_W];
    logic [DIV_W-1:0]  r_dv_dq    [0:DIV_W];
    t_mass             r_dv_mass  [0:DIV_W];
    t_vel              r_dv_vel   [0:DIV_W];
    t_noise            r_dv_noise [0:DIV_W];

    t_mass             in_mass;
    logic [DIV_W-1:0]  in_dividend;
    assign in_mass = (i_s_tdata[55:32] == '0) ? MASS_W'(1) : i_s_tdata[55:32];
    assign in_dividend = {({1'b0, c1} + 18'd65536), 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DIV_W; k++) r_dv_valid[k] <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= i_s_tvalid;
            for (int k = 0; k < DIV_W; k++) r_dv_valid[k+1] <= r_dv_valid[k];
        end
    end

    // restoring division, one quotient bit per stage
    always_ff @(posedge i_clk) begin
        logic [MASS_W:0] t;
        logic            ge;
        if (en) begin
            r_dv_rem[0]   <= '0;
            r_dv_dq[0]    <= in_dividend;
            r_dv_mass[0]  <= in_mass;
            r_dv_vel[0]   <= i_s_tdata[31:0];
            r_dv_noise[0] <= i_s_tdata[71:56];
            for (int k = 0; k < DIV_W; k++) begin
                t  = {r_dv_rem[k], r_dv_dq[k][DIV_W-1]};
                ge = (t >= {1'b0, r_dv_mass[k]});
                r_dv_rem[k+1]   <= ge ? MASS_W'(t - {1'b0, r_dv_mass[k]})
                                      : t[MASS_W-1:0];
                r_dv_dq[k+1]    <= {r_dv_dq[k][DIV_W-2:0], ge};
                r_dv_mass[k+1]  <= r_dv_mass[k];
                r_dv_vel[k+1]   <= r_dv_vel[k];
                r_dv_noise[k+1] <= r_dv_noise[k];
            end
        end
    end

    // square root stages, stage 0 takes the quotient
    logic              r_sq_valid [0:SQ_N];
    logic [SREM_W-1:0] r_sq_rem   [0:SQ_N];
    logic [ROOT_W-1:0] r_sq_root  [0:SQ_N];
    logic [DIV_W-1:0]  r_sq_rad   [0:SQ_N];
    t_vel              r_sq_vel   [0:SQ_N];
    t_noise            r_sq_noise [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= SQ_N; j++) r_sq_valid[j] <= 1'b0;
        end else if (en) begin
            r_sq_valid[0] <= r_dv_valid[DIV_W];
            for (int j = 0; j < SQ_N; j++) r_sq_valid[j+1] <= r_sq_valid[j];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [SREM_W+1:0] t;
        logic [SREM_W+1:0] trial;
        logic              ge;
        if (en) begin
            r_sq_rem[0]   <= '0;
            r_sq_root[0]  <= '0;
            r_sq_rad[0]   <= r_dv_dq[DIV_W];
            r_sq_vel[0]   <= r_dv_vel[DIV_W];
            r_sq_noise[0] <= r_dv_noise[DIV_W];
            for (int j = 0; j < SQ_N; j++) begin
                t     = {r_sq_rem[j], r_sq_rad[j][DIV_W-1:DIV_W-2]};
                trial = {2'b00, r_sq_root[j], 2'b01};
                ge    = (t >= trial);
                r_sq_rem[j+1]   <= ge ? SREM_W'(t - trial) : t[SREM_W-1:0];
                r_sq_root[j+1]  <= {r_sq_root[j][ROOT_W-2:0], ge};
                r_sq_rad[j+1]   <= {r_sq_rad[j][DIV_W-3:0], 2'b00};
                r_sq_vel[j+1]   <= r_sq_vel[j];
                r_sq_noise[j+1] <= r_sq_noise[j];
            end
        end
    end

    // multiply stage 1: c2 * root and c1 * v
    logic                    r_p1_valid, r_p2_valid, r_p3_valid;
    logic [PROD_W-1:0]       r_p1_prod;
    logic signed [CV_W-1:0]  r_p1_cv, r_p2_cv, r_p3_cv;
    t_noise                  r_p1_noise, r_p2_noise;
    logic [A_W-1:0]          r_p2_a;
    logic signed [AN_W-1:0]  r_p3_an;
    logic [PROD_W-1:0]       prod_rnd;

    assign prod_rnd = r_p1_prod + PROD_W'(1 << 19);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (en) begin
            r_p1_valid <= r_sq_valid[SQ_N];
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_prod  <= PROD_W'(r_nscale) * PROD_W'(r_sq_root[SQ_N]);
            r_p1_cv    <= $signed({1'b0, c1}) * $signed(r_sq_vel[SQ_N]);
            r_p1_noise <= r_sq_noise[SQ_N];
            // round half up to Q.12
            r_p2_a     <= prod_rnd[PROD_W-1:20];
            r_p2_cv    <= r_p1_cv;
            r_p2_noise <= r_p1_noise;
            // multiply stage 3: amplitude times noise
            r_p3_an    <= $signed({1'b0, r_p2_a}) * $signed(r_p2_noise);
            r_p3_cv    <= r_p2_cv;
        end
    end

    // final sum, rounding and saturation
    logic signed [SUM_W-1:0]    sum;
    logic signed [SUM_W-17:0]   rsh;
    logic                       sat_hi, sat_lo;
    logic [31:0]                r_out_data;
    logic                       r_out_sat;

    assign sum = SUM_W'(r_p3_cv) + (SUM_W'(r_p3_an) <<< 4) + SUM_W'(32768);
    assign rsh = sum[SUM_W-1:16];
    assign sat_hi = !rsh[SUM_W-17] && (rsh[SUM_W-18:31] != '0);
    assign sat_lo = rsh[SUM_W-17] && (rsh[SUM_W-18:31] != '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_p3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= sat_hi ? 32'h7FFF_FFFF :
                          sat_lo ? 32'h8000_0000 : rsh[31:0];
            r_out_sat  <= sat_hi || sat_lo;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

`ifndef ASSERT_OFF
    // a saturated result is always one of the range limits
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |->
            (o_m_tdata == 32'h7FFF_FFFF) || (o_m_tdata == 32'h8000_0000))
        else $error("saturated flag without limit value");

    // an accepted transaction lands in the first divider stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_dv_valid[0])
        else $error("accepted transaction not captured");

    // a held output keeps the pipeline frozen
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(r_p3_valid))
        else $error("pipeline moved during output stall");
`endif

endmodule
